// ===== hw/rtl/pcrc_pkg.sv =====
// shared types, register codes and the byte-wide crc update for the packet crc block
package pcrc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_POLYNOMIAL = 2'd0,
        REG_START      = 2'd1
    } cfg_reg_t;

    localparam logic [15:0] POLY_RESET  = 16'hA001;
    localparam logic [15:0] START_RESET = 16'h0000;

    // kind of a result beat
    localparam logic KIND_CRC_BYTE = 1'b0;
    localparam logic KIND_VERDICT  = 1'b1;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       append_mode;
        logic       last_byte;
    } item_beat_t;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       crc_matches;
        logic       result_kind;
        logic       last_result;
    } result_beat_t;

    // results produced by one input beat, oldest first
    typedef struct packed {
        logic [1:0]   count;
        result_beat_t first;
        result_beat_t second;
    } result_push_t;

    // reflected crc over one byte, lsb first
    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [15:0] poly,
                                             logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/pcrc_core.sv =====
// packet state, crc register and result formation for one beat
module pcrc_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcrc_pkg::item_beat_t    beat,
    input  logic                    advance,
    input  logic [15:0]             poly,
    input  logic [15:0]             start,
    output pcrc_pkg::result_push_t  push
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        mode_reg, mode_next;
    logic        in_packet_reg, in_packet_next;

    logic        first;
    logic        mode;
    logic [15:0] crc_base;
    logic [1:0]  hc;
    logic [7:0]  h0, h1;
    logic [7:0]  feed_byte;
    logic [15:0] crc_fed;
    logic        ok;

    // values at the start of this beat, with packet start folded in
    always_comb
    begin
        first    = !in_packet_reg;
        mode     = first ? beat.append_mode : mode_reg;
        crc_base = first ? start : crc_reg;
        hc       = first ? 2'd0 : held_count_reg;
        h0       = first ? 8'h00 : held0_reg;
        h1       = first ? 8'h00 : held1_reg;
        feed_byte = mode ? beat.data_byte : h0;
        crc_fed  = pcrc_pkg::crc_feed(crc_base, poly, feed_byte);
    end

    // next state and results
    always_comb
    begin
        mode_next       = mode;
        in_packet_next  = !beat.last_byte;
        crc_next        = crc_base;
        held0_next      = h0;
        held1_next      = h1;
        held_count_next = hc;
        if (mode)
        begin
            crc_next = crc_fed;
        end
        else if (hc[1])
        begin
            crc_next   = crc_fed;
            held0_next = h1;
            held1_next = beat.data_byte;
        end
        else
        begin
            if (hc[0])
                held1_next = beat.data_byte;
            else
                held0_next = beat.data_byte;
            held_count_next = hc + 2'd1;
        end
        ok = held_count_next[1] && ({held0_next, held1_next} == crc_next);

        push = '0;
        if (beat.last_byte)
        begin
            if (mode)
            begin
                push.count              = 2'd2;
                push.first.out_byte     = crc_next[15:8];
                push.first.result_kind  = pcrc_pkg::KIND_CRC_BYTE;
                push.second.out_byte    = crc_next[7:0];
                push.second.result_kind = pcrc_pkg::KIND_CRC_BYTE;
                push.second.last_result = 1'b1;
            end
            else
            begin
                push.count             = 2'd1;
                push.first.crc_matches = ok;
                push.first.result_kind = pcrc_pkg::KIND_VERDICT;
                push.first.last_result = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= pcrc_pkg::START_RESET;
            held_count_reg <= 2'd0;
            mode_reg       <= 1'b0;
            in_packet_reg  <= 1'b0;
        end
        else if (advance)
        begin
            crc_reg        <= crc_next;
            held_count_reg <= held_count_next;
            mode_reg       <= mode_next;
            in_packet_reg  <= in_packet_next;
        end
    end

    // held bytes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

// ===== hw/rtl/pcrc_outq.sv =====
// two-entry result queue feeding the result port
module pcrc_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcrc_pkg::result_push_t  push,
    input  logic                    push_en,
    output logic [1:0]              room,
    output logic                    result_valid,
    input  logic                    result_stall,
    output pcrc_pkg::result_beat_t  result
);

    pcrc_pkg::result_beat_t q_reg [2];
    pcrc_pkg::result_beat_t q_next [2];
    logic [1:0] count_reg, count_next;
    logic [1:0] count_kept;
    logic [1:0] push_n;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign result       = q_reg[0];
    assign pop          = result_valid && !result_stall;
    assign room         = 2'd2 - count_reg + {1'b0, pop};
    assign push_n       = push_en ? push.count : 2'd0;

    // shift out the popped beat, then append new ones
    always_comb
    begin
        q_next[0]  = pop ? q_reg[1] : q_reg[0];
        q_next[1]  = q_reg[1];
        count_kept = count_reg - {1'b0, pop};
        for (int i = 0; i < 2; i++)
        begin
            if (push_n != 2'd0 && count_kept == 2'(i))
                q_next[i] = push.first;
            if (push_n == 2'd2 && count_kept + 2'd1 == 2'(i))
                q_next[i] = push.second;
        end
        count_next = count_kept + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // queue never holds more than two beats
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    // producer never pushes more than there is room for
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push_n <= room)
        else $error("result queue overfilled");

    // a pair pushed into an empty queue comes out in order
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 && push_n == 2'd2) |=>
            (count_reg == 2'd2 && q_reg[0] == $past(push.first)
             && q_reg[1] == $past(push.second)))
        else $error("result pair lost or reordered");

endmodule

// ===== hw/rtl/packet_crc16_append_check_top.sv =====
// top level of the packet crc-16 append and check block
// a last byte is held in the input register, then its results in the result queue
// throughput: one byte per cycle; an append packet's last byte puts out two beats,
//   and the input stalls while the two-entry result queue lacks room for a beat's results
// crc over a byte is eight unrolled shift-and-xor steps between input and result registers
// reset: asynchronous active low, polynomial 0xA001, start 0x0000, waiting for a packet start
module packet_crc16_append_check_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  pcrc_pkg::item_beat_t    item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output pcrc_pkg::result_beat_t  result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data
);

    logic                   s1_valid_reg;
    pcrc_pkg::item_beat_t   s1_beat_reg;
    logic [15:0]            poly_reg;
    logic [15:0]            start_reg;
    pcrc_pkg::result_push_t push;
    logic [1:0]             room;
    logic                   advance;

    assign cfg_ready  = 1'b1;
    assign advance    = s1_valid_reg && (push.count <= room);
    assign item_stall = s1_valid_reg && !advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg  <= pcrc_pkg::POLY_RESET;
            start_reg <= pcrc_pkg::START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcrc_pkg::REG_POLYNOMIAL: poly_reg  <= cfg_data;
                pcrc_pkg::REG_START:      start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!item_stall)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            s1_beat_reg <= item;
    end

    pcrc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (s1_beat_reg),
        .advance (advance),
        .poly    (poly_reg),
        .start   (start_reg),
        .push    (push)
    );

    pcrc_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_en      (advance),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
